// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the RTL top, matrix_inverse_adjugate.sv.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== hw/rtl/mia_pkg.sv =====
// Shared types and saturating Q16.16 helpers for the adjugate inverse.
// No dependencies.
package mia_pkg;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic [63:0] mag64(input logic [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return s;
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		if (a[63] != b[63] && d[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return d;
	endfunction

	function automatic logic [63:0] sat_neg(input logic [63:0] a);
		return sat_sub(64'd0, a);
	endfunction

endpackage

// ===== hw/rtl/mia_qmul.sv =====
// Iterative Q16.16 multiplier: four 32x32 partial products, floor shift, clip.
// Depends on mia_pkg.
module mia_qmul import mia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] y,
	output unit_stat_t  stat
);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_MUL  = 2'd1;
	localparam logic [1:0] M_NEG  = 2'd2;
	localparam logic [1:0] M_SAT  = 2'd3;

	logic [1:0]   st_q;
	logic [1:0]   cnt_q;
	logic [63:0]  ua_q, ub_q, y_q;
	logic         neg_q, done_q;
	logic [127:0] acc_q;
	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [1:0]   nsum;
	logic [6:0]   sh;
	logic [63:0]  sat_y;

	always_comb begin
		ah = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
		bh = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
		pp = {32'd0, ah} * {32'd0, bh};
		nsum = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
		sh = {nsum, 5'd0};
		// keep the floor-shifted low word unless the top bits are not its sign fill
		if (acc_q[127:80] != {48{acc_q[79]}})
			sat_y = acc_q[127] ? S64_MIN : S64_MAX;
		else
			sat_y = acc_q[79:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				M_IDLE: if (start) st_q <= M_MUL;
				M_MUL: if (cnt_q == 2'd3) st_q <= M_NEG;
				M_NEG: st_q <= M_SAT;
				M_SAT: begin
					done_q <= 1'b1;
					st_q <= M_IDLE;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				ua_q <= mag64(a);
				ub_q <= mag64(b);
				neg_q <= a[63] ^ b[63];
				acc_q <= '0;
				cnt_q <= 2'd0;
			end
			M_MUL: begin
				acc_q <= acc_q + ({64'd0, pp} << sh);
				cnt_q <= cnt_q + 2'd1;
			end
			M_NEG: if (neg_q) acc_q <= ~acc_q + 128'd1;
			M_SAT: y_q <= sat_y;
			default: ;
		endcase
	end

	assign y = y_q;
	assign stat.busy = (st_q != M_IDLE);
	assign stat.done = done_q;

endmodule

// ===== hw/rtl/mia_qdiv.sv =====
// Bit-serial restoring divider: (num << 16) / den, truncated, clipped to Q16.16.
// Depends on mia_pkg.
module mia_qdiv import mia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic [31:0] q,
	output logic        sat,
	output unit_stat_t  stat
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_FIN  = 2'd2;

	logic [1:0]  st_q;
	logic [5:0]  cnt_q;
	logic [63:0] r_q, lo_q, q_q, dm_q;
	logic        neg_q, done_q, sat_q;
	logic [31:0] y_q;
	logic [63:0] nm, dm, limit;
	logic [64:0] rs;
	logic        ge;
	logic [31:0] qq;
	logic        qsat;

	always_comb begin
		nm = mag64(num);
		dm = mag64(den);
		rs = {r_q, lo_q[63]};
		ge = (rs >= {1'b0, dm_q});
		limit = neg_q ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
		qsat = (q_q > limit);
		qq = qsat ? limit[31:0] : q_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: if (start) begin
					if (dm == 64'd0 || {48'd0, nm[63:48]} >= dm)
						done_q <= 1'b1;
					else
						st_q <= D_RUN;
				end
				D_RUN: if (cnt_q == 6'd63) st_q <= D_FIN;
				D_FIN: begin
					done_q <= 1'b1;
					st_q <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: if (start) begin
				neg_q <= num[63] ^ den[63];
				dm_q <= dm;
				r_q <= {48'd0, nm[63:48]};
				lo_q <= {nm[47:0], 16'd0};
				q_q <= '0;
				cnt_q <= 6'd0;
				// preset the clipped result; it stands when the quotient cannot fit, else D_FIN overwrites it
				sat_q <= 1'b1;
				y_q <= (num[63] ^ den[63]) ? Q_MIN : Q_MAX;
			end
			D_RUN: begin
				r_q <= ge ? 64'(rs - {1'b0, dm_q}) : rs[63:0];
				lo_q <= {lo_q[62:0], 1'b0};
				q_q <= {q_q[62:0], ge};
				cnt_q <= cnt_q + 6'd1;
			end
			D_FIN: begin
				sat_q <= qsat;
				y_q <= neg_q ? (32'd0 - qq) : qq;
			end
			default: ;
		endcase
	end

	assign q = y_q;
	assign sat = sat_q;
	assign stat.busy = (st_q != D_IDLE);
	assign stat.done = done_q;

endmodule

// ===== hw/rtl/matrix_inverse_adjugate.sv =====
// Channel   | Direction | Handshake               | Payload
// input     | in        | in_valid / in_stall     | element_value
// result    | out       | out_valid / out_stall   | result_value, result_row, result_col,
//           |           |                         | singular, saturated, last_element
// config    | in        | cfg_valid / cfg_ready   | cfg_data (det_epsilon)
//
// Loading takes one item per cycle while in_stall is low; the item that completes a
// matrix raises in_stall. Minors build up in a table memory through one shared
// multiplier, then each result of a regular matrix takes one 64-step divider pass.
// out_stall holds the result register and the sequencer; the last result may wait
// while the next matrix loads. Reset (arst_n low) clears control state; det_epsilon is 1.
//
// Top level of the adjugate inverse. Depends on mia_pkg, mia_qmul, mia_qdiv
// and assert_macros.svh.
`include "assert_macros.svh"

module matrix_inverse_adjugate import mia_pkg::*; #(
	parameter int MATRIX_SIZE = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] element_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic [1:0]         result_row,
	output logic [1:0]         result_col,
	output logic               singular,
	output logic               saturated,
	output logic               last_element,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	localparam int N = MATRIX_SIZE;
	localparam int AW = 2 * N;
	localparam int DEPTH = 1 << AW;
	localparam logic [1:0] LAST = 2'(N - 1);
	localparam logic [2:0] K_TOP = 3'(N - 1);
	localparam logic [N-1:0] FULL = '1;
	localparam bit HAS_MINORS = (N > 2);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_MASK  = 4'd1;
	localparam logic [3:0] S_COL   = 4'd2;
	localparam logic [3:0] S_CE    = 4'd3;
	localparam logic [3:0] S_CS    = 4'd4;
	localparam logic [3:0] S_CM    = 4'd5;
	localparam logic [3:0] S_CW    = 4'd6;
	localparam logic [3:0] S_WR    = 4'd7;
	localparam logic [3:0] S_DFIN  = 4'd8;
	localparam logic [3:0] S_ORD   = 4'd9;
	localparam logic [3:0] S_OCAP  = 4'd10;
	localparam logic [3:0] S_OWAIT = 4'd11;
	localparam logic [3:0] S_OPUT  = 4'd12;

	function automatic logic [N-1:0] oh(input logic [1:0] i);
		return {{(N-1){1'b0}}, 1'b1} << i;
	endfunction

	// Minor table: entry {rows, cols} holds the determinant of that minor.
	// One-hot pairs hold the loaded elements themselves.
	logic [63:0] mem [DEPTH];
	logic [63:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	logic [63:0]   wdata;

	logic [3:0]    state_q;
	logic [1:0]    lr_q, lc_q, c_q, or_q, oc_q, r0;
	logic [2:0]    k_q;
	logic [AW-1:0] idx_q;
	logic          plus_q, mode_q, sing_q;
	logic [63:0]   acc_q, e_q, det_q;
	logic [15:0]   eps_q;
	logic [31:0]   val_q, out_val_q;
	logic          sat_q, out_valid_q, out_sing_q, out_sat_q, out_last_q;
	logic [1:0]    out_row_q, out_col_q;
	logic [N-1:0]  rmask, cmask;
	logic          mask_ok, last_out, out_load;

	logic          mul_start, div_start;
	logic [63:0]   mul_b, mul_y, div_num;
	logic [31:0]   div_q;
	logic          div_sat;
	unit_stat_t    mul_st, div_st;

	assign rmask = idx_q[AW-1:N];
	assign cmask = idx_q[N-1:0];
	assign mask_ok = (3'($countones(rmask)) == k_q) && (3'($countones(cmask)) == k_q);
	assign last_out = (or_q == LAST) && (oc_q == LAST);
	// advance the result register when it is empty or being taken
	assign out_load = (state_q == S_OPUT) && (!out_valid_q || !out_stall);

	// expand each minor along its lowest remaining row
	always_comb begin
		r0 = 2'd0;
		for (int b = N - 1; b >= 0; b--)
			if (rmask[b]) r0 = 2'(b);
	end

	always_comb begin
		case (state_q)
			S_CE: raddr = mode_q ? {oh(2'd0), oh(c_q)} : {oh(r0), oh(c_q)};
			S_CS: raddr = mode_q ? {FULL & ~oh(2'd0), FULL & ~oh(c_q)}
				: {rmask & ~oh(r0), cmask & ~oh(c_q)};
			S_ORD: raddr = sing_q ? {oh(or_q), oh(oc_q)}
				: {FULL & ~oh(oc_q), FULL & ~oh(or_q)};
			default: raddr = {oh(lr_q), oh(lc_q)};
		endcase
		we = (state_q == S_LOAD && in_valid) || state_q == S_WR;
		waddr = (state_q == S_WR) ? idx_q : {oh(lr_q), oh(lc_q)};
		wdata = (state_q == S_WR) ? acc_q : {{32{element_value[31]}}, element_value};
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// cofactor sign goes on before the product in the determinant pass
	assign mul_b = (mode_q && c_q[0]) ? sat_neg(rdata_q) : rdata_q;
	assign mul_start = (state_q == S_CM);
	assign div_start = (state_q == S_OCAP) && !sing_q;
	assign div_num = (or_q[0] ^ oc_q[0]) ? sat_neg(rdata_q) : rdata_q;

	mia_qmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (e_q),
		.b      (mul_b),
		.y      (mul_y),
		.stat   (mul_st)
	);

	mia_qdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_q),
		.q      (div_q),
		.sat    (div_sat),
		.stat   (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			lr_q <= 2'd0;
			lc_q <= 2'd0;
			k_q <= 3'd2;
			idx_q <= '0;
			c_q <= 2'd0;
			or_q <= 2'd0;
			oc_q <= 2'd0;
			mode_q <= 1'b0;
			plus_q <= 1'b1;
			sing_q <= 1'b0;
			acc_q <= '0;
			e_q <= '0;
			val_q <= '0;
			sat_q <= 1'b0;
			det_q <= '0;
			eps_q <= 16'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) eps_q <= cfg_data;
			// hold the result until the far side takes it
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_LOAD: if (in_valid) begin
					if (lc_q == LAST) begin
						lc_q <= 2'd0;
						if (lr_q == LAST) begin
							lr_q <= 2'd0;
							k_q <= 3'd2;
							idx_q <= '0;
							c_q <= 2'd0;
							acc_q <= '0;
							mode_q <= !HAS_MINORS;
							state_q <= HAS_MINORS ? S_MASK : S_COL;
						end else
							lr_q <= lr_q + 2'd1;
					end else
						lc_q <= lc_q + 2'd1;
				end
				S_MASK: begin
					if (mask_ok) begin
						acc_q <= '0;
						plus_q <= 1'b1;
						c_q <= 2'd0;
						state_q <= S_COL;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (&idx_q) begin
							if (k_q == K_TOP) begin
								mode_q <= 1'b1;
								acc_q <= '0;
								c_q <= 2'd0;
								state_q <= S_COL;
							end else
								k_q <= k_q + 3'd1;
						end
					end
				end
				S_COL: begin
					if (mode_q || cmask[c_q])
						state_q <= S_CE;
					else if (c_q == LAST)
						state_q <= S_WR;
					else
						c_q <= c_q + 2'd1;
				end
				S_CE: state_q <= S_CS;
				S_CS: begin
					e_q <= rdata_q;
					state_q <= S_CM;
				end
				S_CM: state_q <= S_CW;
				S_CW: if (mul_st.done) begin
					if (mode_q || plus_q)
						acc_q <= sat_add(acc_q, mul_y);
					else
						acc_q <= sat_sub(acc_q, mul_y);
					plus_q <= !plus_q;
					if (c_q == LAST)
						state_q <= mode_q ? S_DFIN : S_WR;
					else begin
						c_q <= c_q + 2'd1;
						state_q <= S_COL;
					end
				end
				S_WR: begin
					idx_q <= idx_q + 1'b1;
					if (&idx_q && k_q == K_TOP) begin
						mode_q <= 1'b1;
						acc_q <= '0;
						c_q <= 2'd0;
						state_q <= S_COL;
					end else begin
						if (&idx_q) k_q <= k_q + 3'd1;
						state_q <= S_MASK;
					end
				end
				S_DFIN: begin
					det_q <= acc_q;
					sing_q <= (mag64(acc_q) <= {48'd0, eps_q});
					mode_q <= 1'b0;
					or_q <= 2'd0;
					oc_q <= 2'd0;
					state_q <= S_ORD;
				end
				S_ORD: state_q <= S_OCAP;
				S_OCAP: begin
					if (sing_q) begin
						val_q <= rdata_q[31:0];
						sat_q <= 1'b0;
						state_q <= S_OPUT;
					end else
						state_q <= S_OWAIT;
				end
				S_OWAIT: if (div_st.done) begin
					val_q <= div_q;
					sat_q <= div_sat;
					state_q <= S_OPUT;
				end
				S_OPUT: if (out_load) begin
					if (oc_q == LAST) begin
						oc_q <= 2'd0;
						if (or_q == LAST) begin
							or_q <= 2'd0;
							state_q <= S_LOAD;
						end else begin
							or_q <= or_q + 2'd1;
							state_q <= S_ORD;
						end
					end else begin
						oc_q <= oc_q + 2'd1;
						state_q <= S_ORD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// result payload: load only when the slot is free
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q <= val_q;
			out_row_q <= or_q;
			out_col_q <= oc_q;
			out_sing_q <= sing_q;
			out_sat_q <= sat_q;
			out_last_q <= last_out;
		end
	end

	assign in_stall = (state_q != S_LOAD);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign result_value = out_val_q;
	assign result_row = out_row_q;
	assign result_col = out_col_q;
	assign singular = out_sing_q;
	assign saturated = out_sat_q;
	assign last_element = out_last_q;

	`ASSERT_IMPL(a_sing_no_sat, out_valid && singular, !saturated)
	`ASSERT_IMPL(a_last_corner, out_valid && last_element, result_row == LAST && result_col == LAST)
	`ASSERT_NEVER(a_units_exclusive, mul_st.busy && div_st.busy)

endmodule

// ===== tb/mia_checker.sv =====
`timescale 1ns / 1ps
// Result checker for matrix_inverse_adjugate: snoops the input, result and
// config channels, predicts each inverse in Q16.16 and compares field by field.
// Depends on nothing but the port list of the block.
module mia_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] element_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] result_value,
	input  logic [1:0]         result_row,
	input  logic [1:0]         result_col,
	input  logic               singular,
	input  logic               saturated,
	input  logic               last_element,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  row;
		logic [1:0]  col;
		logic        sing;
		logic        sat;
		logic        last;
	} inv_elem_t;

	localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

	inv_elem_t   inverse_q[$];
	logic [31:0] loaded [16];
	logic [15:0] epsilon;
	int          fill;

	assign pending = inverse_q.size();

	function automatic logic signed [63:0] add_s(input logic signed [63:0] a, b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? MIN64 : MAX64;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sub_s(input logic signed [63:0] a, b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? MIN64 : MAX64;
		return s[63:0];
	endfunction

	// exact product, floor shift by 16, clip to 64 bits
	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a, b);
		logic signed [127:0] wa, wb, p;
		wa = a;
		wb = b;
		p = (wa * wb) >>> 16;
		if (p[127:63] != {65{p[63]}})
			return p[127] ? MIN64 : MAX64;
		return p[63:0];
	endfunction

	function automatic logic signed [63:0] elem(input int r, input int c);
		logic signed [31:0] e;
		e = loaded[r * 4 + c];
		return 64'(e);
	endfunction

	function automatic logic signed [63:0] det2(input int ra, rb, ca, cb);
		return sub_s(fx_mul(elem(ra, ca), elem(rb, cb)), fx_mul(elem(ra, cb), elem(rb, ca)));
	endfunction

	// signed minor without row i and column j, expanded along its top row
	function automatic logic signed [63:0] cofactor(input int i, input int j);
		int rs [3];
		int cs [3];
		int nr, nc;
		logic signed [63:0] acc;
		nr = 0;
		nc = 0;
		for (int k = 0; k < 4; k++) begin
			if (k != i) begin
				rs[nr] = k;
				nr++;
			end
			if (k != j) begin
				cs[nc] = k;
				nc++;
			end
		end
		acc = fx_mul(elem(rs[0], cs[0]), det2(rs[1], rs[2], cs[1], cs[2]));
		acc = sub_s(acc, fx_mul(elem(rs[0], cs[1]), det2(rs[1], rs[2], cs[0], cs[2])));
		acc = add_s(acc, fx_mul(elem(rs[0], cs[2]), det2(rs[1], rs[2], cs[0], cs[1])));
		return ((i + j) % 2) ? sub_s(64'sd0, acc) : acc;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] a);
		return a[63] ? 64'd0 - a : a;
	endfunction

	task automatic predict_inverse();
		logic signed [63:0] cof [16];
		logic signed [63:0] det;
		logic [127:0]       quo;
		logic [63:0]        nm, dm, limit;
		logic               neg, sing;
		inv_elem_t          r;
		for (int k = 0; k < 16; k++)
			cof[k] = cofactor(k / 4, k % 4);
		det = 64'sd0;
		for (int j = 0; j < 4; j++)
			det = add_s(det, fx_mul(elem(0, j), cof[j]));
		sing = mag(det) <= 64'(epsilon);
		for (int k = 0; k < 16; k++) begin
			r.row = 2'(k / 4);
			r.col = 2'(k % 4);
			r.sing = sing;
			r.last = (k == 15);
			r.sat = 1'b0;
			if (sing) begin
				r.value = loaded[k];
			end else begin
				nm = mag(cof[(k % 4) * 4 + k / 4]);
				dm = mag(det);
				neg = cof[(k % 4) * 4 + k / 4][63] != det[63];
				limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
				quo = {48'd0, nm, 16'd0} / {64'd0, dm};
				if (quo > {64'd0, limit}) begin
					quo = {64'd0, limit};
					r.sat = 1'b1;
				end
				r.value = neg ? 32'd0 - quo[31:0] : quo[31:0];
			end
			inverse_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		inv_elem_t want;
		if (!arst_n) begin
			epsilon = 16'd1;
			fill = 0;
			errors = 0;
			inverse_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				epsilon = cfg_data;
			if (in_valid && !in_stall) begin
				loaded[fill] = element_value;
				fill++;
				if (fill == 16) begin
					fill = 0;
					predict_inverse();
				end
			end
			if (out_valid && !out_stall) begin
				if (inverse_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result value=%h row=%0d col=%0d",
							result_value, result_row, result_col);
				end else begin
					want = inverse_q.pop_front();
					if (want != {result_value, result_row, result_col, singular, saturated,
						last_element}) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp %h %0d %0d %b %b %b got %h %0d %0d %b %b %b",
								want.value, want.row, want.col, want.sing, want.sat,
								want.last, result_value, result_row, result_col,
								singular, saturated, last_element);
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb_matrix_inverse_adjugate.sv =====
`timescale 1ns / 1ps
// Top testbench for matrix_inverse_adjugate: drives matrices and epsilon
// settings, and gives the verdict from the count kept by mia_checker.
module tb_matrix_inverse_adjugate;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] element_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         result_row;
	logic [1:0]         result_col;
	logic               singular;
	logic               saturated;
	logic               last_element;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        cfg_data = '0;
	int                 errors;
	int                 pending;
	int                 burst_left = 0;

	// kinds of random matrix
	typedef enum int {MAT_SMALL, MAT_DUP_ROW, MAT_NOISE, MAT_TINY} mat_kind_t;

	always #4 clk = ~clk;

	matrix_inverse_adjugate i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .element_value(element_value),
		.out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
		.result_row(result_row), .result_col(result_col), .singular(singular),
		.saturated(saturated), .last_element(last_element),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	mia_checker i_checker (.*);

	// Receiver: pick a new stall mode at random whenever the current span runs out; mode 0 never stalls.
	int stall_mode = 0;
	int stall_cnt = 0;
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_cnt = $urandom_range(8, 80);
		end
		stall_cnt--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= $urandom_range(0, 1);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_cnt % 5 == 0);
		endcase
	end

	// Send one item; open a new burst after a random gap when the last one ends.
	task automatic send_element(input logic [31:0] v);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1'b1;
		element_value <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic write_epsilon(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, then hold until every predicted element has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_matrix(input mat_kind_t kind);
		logic [31:0] m [16];
		for (int k = 0; k < 16; k++) begin
			case (kind)
				MAT_SMALL: m[k] = 32'($signed($urandom_range(0, 16)) - 8) << 16
					| 32'($urandom_range(0, 16'hFFFF));
				MAT_TINY: m[k] = (k % 5 == 0) ? 32'($urandom_range(1, 16'h3FF)) :
					32'($urandom_range(0, 16'hFF));
				default: m[k] = $urandom;
			endcase
			// copy row 0 into row 3 to force a zero determinant
			if (kind == MAT_DUP_ROW && k >= 12)
				m[k] = m[k - 12];
		end
		foreach (m[k]) send_element(m[k]);
	endtask

	initial begin
		logic [31:0] extremes [16] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
			32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1,
			32'h0, 32'hFFFF_0000, 32'h0001_0000, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h1, 32'h0, 32'h7FFF_FFFF};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes at reset epsilon, then a diagonal near zero
		foreach (extremes[k]) send_element(extremes[k]);
		for (int k = 0; k < 16; k++)
			send_element((k % 5 == 0) ? 32'h0000_0100 : 32'h0);
		drain();

		// epsilon zero: only an exact zero determinant is singular
		write_epsilon(16'd0);
		send_matrix(MAT_DUP_ROW);
		send_matrix(MAT_TINY);
		send_matrix(MAT_SMALL);
		drain();

		write_epsilon(16'hFFFF);
		send_matrix(MAT_TINY);
		send_matrix(MAT_SMALL);
		drain();

		write_epsilon(16'($urandom));
		for (int n = 0; n < 2; n++)
			send_matrix(mat_kind_t'($urandom_range(0, 3)));
		drain();

		write_epsilon(16'd1);
		send_matrix(MAT_NOISE);
		send_matrix(MAT_DUP_ROW);
		in_valid <= 1'b0;
		drain();
		repeat (100) @(posedge clk);

		if (errors == 0)
			$display("tb_matrix_inverse_adjugate: clean");
		else
			$display("tb_matrix_inverse_adjugate: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_matrix_inverse_adjugate: errors");
		$finish;
	end

endmodule

// ===== matrix_inverse_adjugate.f =====
+incdir+hw/rtl
hw/rtl/mia_pkg.sv
hw/rtl/mia_qmul.sv
hw/rtl/mia_qdiv.sv
hw/rtl/matrix_inverse_adjugate.sv
tb/mia_checker.sv
tb/tb_matrix_inverse_adjugate.sv
